/* rtl/tabular_q_learning_engine_unit_assert.svh */
// Assertion macros shared by the Q-learning engine modules.
`ifndef TABULAR_Q_LEARNING_ENGINE_UNIT_ASSERT_SVH
`define TABULAR_Q_LEARNING_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk, off during reset.
`define TQLE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tqle: assertion failed");

// Next-cycle implication, checked on the rising edge of clk, off during reset.
`define TQLE_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tqle: assertion failed");

`endif

/* rtl/tqle_pkg.sv */
// Types, constants and microcode step codes of the Q-learning engine.
package tqle_pkg;

    // Table geometry
    localparam int IDX_W       = 4;
    localparam int ADDR_W      = 3 * IDX_W;
    localparam int TABLE_DEPTH = 1 << ADDR_W;
    localparam int Q_W         = 32;
    localparam int FRAC_W      = 16;

    // Actions scanned by greedy choice and next-state maximum
    localparam int NUM_PRICES = 16;
    localparam logic [IDX_W-1:0] LAST_ACT = IDX_W'(NUM_PRICES - 1);

    // Register reset values (0.125 and about 0.9)
    localparam logic [FRAC_W-1:0] ALPHA_RESET = 16'd8192;
    localparam logic [FRAC_W-1:0] GAMMA_RESET = 16'd58982;

    // Register indexes
    localparam logic CFG_LEARNING_RATE = 1'b0;
    localparam logic CFG_DISCOUNT      = 1'b1;

    // Stream widths
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    // Microcode step addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t S_CLR   = 4'd0;
    localparam step_t S_IDLE  = 4'd1;
    localparam step_t S_EXP   = 4'd2;
    localparam step_t S_EXP2  = 4'd3;
    localparam step_t S_GSCAN = 4'd4;
    localparam step_t S_GTAIL = 4'd5;
    localparam step_t S_NSCAN = 4'd6;
    localparam step_t S_NTAIL = 4'd7;
    localparam step_t S_OLD   = 4'd8;
    localparam step_t S_T     = 4'd9;
    localparam step_t S_P     = 4'd10;
    localparam step_t S_NEW   = 4'd11;
    localparam step_t S_WR    = 4'd12;
    localparam step_t S_EMIT  = 4'd13;
    localparam step_t S_LAST  = S_EMIT;

    // Sequencer jump kinds
    typedef enum logic [2:0] {
        J_NEXT      = 3'd0,
        J_GOTO      = 3'd1,
        J_DISPATCH  = 3'd2,
        J_LOOP_SCAN = 3'd3,
        J_LOOP_CLR  = 3'd4,
        J_WAIT_OUT  = 3'd5
    } jump_t;

    // Table read address source
    typedef enum logic [1:0] {
        A_CUR_CNT = 2'd0,
        A_NXT_CNT = 2'd1,
        A_CUR_RND = 2'd2,
        A_CUR_ACT = 2'd3
    } addr_sel_t;

    // One control word
    typedef struct packed {
        jump_t     jmp;
        step_t     target;
        logic      in_rdy;
        addr_sel_t addr_sel;
        logic      scan;
        logic      cmp_en;
        logic      first_ld;
        logic      ld_exp;
        logic      ld_old;
        logic      ld_t;
        logic      ld_p;
        logic      ld_new;
        logic      wr_upd;
        logic      clr_wr;
        logic      out_ld;
    } ucw_t;

    // One input request
    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  own_price_idx;
        logic [IDX_W-1:0]  rival_price_idx;
        logic [IDX_W-1:0]  action_idx;
        logic signed [Q_W-1:0] reward;
        logic [IDX_W-1:0]  next_own_idx;
        logic [IDX_W-1:0]  next_rival_idx;
        logic              explore;
        logic [IDX_W-1:0]  random_action;
    } in_item_t;

    // Datapath status
    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic out_free;
    } dp_status_t;

    // Everything the sequencer branches on
    typedef struct packed {
        logic       in_valid;
        logic       in_cmd;
        logic       in_explore;
        dp_status_t dp;
    } seq_status_t;

endpackage

/* rtl/tqle_ucode_rom.sv */
// Microcode table: one control word per sequencer step.
module tqle_ucode_rom (
    input  tqle_pkg::step_t upc,
    output tqle_pkg::ucw_t  cw
);
    import tqle_pkg::*;

    // Program
    always_comb
    begin
        cw          = '0;
        cw.jmp      = J_NEXT;
        cw.target   = S_IDLE;
        cw.addr_sel = A_CUR_CNT;
        unique case (upc)
            S_CLR:
            begin
                cw.jmp    = J_LOOP_CLR;
                cw.clr_wr = 1'b1;
            end
            S_IDLE:
            begin
                cw.jmp    = J_DISPATCH;
                cw.in_rdy = 1'b1;
            end
            S_EXP:
            begin
                cw.addr_sel = A_CUR_RND;
            end
            S_EXP2:
            begin
                cw.jmp    = J_GOTO;
                cw.target = S_EMIT;
                cw.ld_exp = 1'b1;
            end
            S_GSCAN:
            begin
                cw.jmp      = J_LOOP_SCAN;
                cw.addr_sel = A_CUR_CNT;
                cw.scan     = 1'b1;
                cw.cmp_en   = 1'b1;
                cw.first_ld = 1'b1;
            end
            S_GTAIL:
            begin
                cw.jmp      = J_GOTO;
                cw.target   = S_EMIT;
                cw.cmp_en   = 1'b1;
                cw.first_ld = 1'b1;
            end
            S_NSCAN:
            begin
                cw.jmp      = J_LOOP_SCAN;
                cw.addr_sel = A_NXT_CNT;
                cw.scan     = 1'b1;
                cw.cmp_en   = 1'b1;
            end
            S_NTAIL:
            begin
                cw.addr_sel = A_CUR_ACT;
                cw.cmp_en   = 1'b1;
            end
            S_OLD:   cw.ld_old = 1'b1;
            S_T:     cw.ld_t   = 1'b1;
            S_P:     cw.ld_p   = 1'b1;
            S_NEW:   cw.ld_new = 1'b1;
            S_WR:    cw.wr_upd = 1'b1;
            S_EMIT:
            begin
                cw.jmp    = J_WAIT_OUT;
                cw.target = S_IDLE;
                cw.out_ld = 1'b1;
            end
            default:
            begin
                cw.jmp    = J_GOTO;
                cw.target = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tqle_sequencer.sv */
// Step counter with conditional jumps for the microcoded control.
module tqle_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tqle_pkg::ucw_t        cw,
    input  tqle_pkg::seq_status_t st,
    output tqle_pkg::step_t       upc
);
    import tqle_pkg::*;

    step_t upc_reg;
    step_t upc_next;
    step_t upc_inc;

    assign upc_inc = step_t'(upc_reg + 1'b1);
    assign upc     = upc_reg;

    // Next step
    always_comb
    begin
        upc_next = upc_reg;
        unique case (cw.jmp)
            J_NEXT:      upc_next = upc_inc;
            J_GOTO:      upc_next = cw.target;
            J_DISPATCH:
            begin
                priority if (!st.in_valid) upc_next = upc_reg;
                else if (st.in_cmd)        upc_next = S_NSCAN;
                else if (st.in_explore)    upc_next = S_EXP;
                else                       upc_next = S_GSCAN;
            end
            J_LOOP_SCAN: upc_next = st.dp.scan_last ? upc_inc : upc_reg;
            J_LOOP_CLR:  upc_next = st.dp.clr_last ? upc_inc : upc_reg;
            J_WAIT_OUT:  upc_next = st.dp.out_free ? cw.target : upc_reg;
            default:     upc_next = S_IDLE;
        endcase
    end

    // Step register; reset starts the table clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_CLR;
        else
            upc_reg <= upc_next;
    end

`include "tabular_q_learning_engine_unit_assert.svh"

    `TQLE_ASSERT_IMP(a_step_range, 1'b1, upc_reg <= S_LAST)
    `TQLE_ASSERT_NXT(a_leave_idle, cw.in_rdy && st.in_valid, upc_reg != S_IDLE)
    `TQLE_ASSERT_NXT(a_clear_hold, upc_reg == S_CLR && !st.dp.clr_last, upc_reg == S_CLR)

endmodule

/* rtl/tqle_datapath.sv */
// Q table memory, scan compare, update arithmetic and output register.
module tqle_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tqle_pkg::ucw_t                cw,
    input  logic                          in_accept,
    input  tqle_pkg::in_item_t            item,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [tqle_pkg::FRAC_W-1:0]   cfg_data,
    input  logic                          m_tready,
    output tqle_pkg::dp_status_t          status,
    output logic                          out_vld,
    output logic [tqle_pkg::IDX_W-1:0]    out_act,
    output logic signed [tqle_pkg::Q_W-1:0] out_q
);
    import tqle_pkg::*;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam int G_W = FRAC_W + Q_W - 1;
    localparam int T_W = Q_W + 2;
    localparam int P_W = T_W + FRAC_W;

    // Registers
    logic [FRAC_W-1:0]      alpha_reg;
    logic [FRAC_W-1:0]      gamma_reg;
    in_item_t               item_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [IDX_W-1:0]       cnt_reg;
    logic [IDX_W-1:0]       cmp_idx_reg;
    logic                   cmp_vld_reg;
    logic signed [Q_W-1:0]  rdata_reg;
    logic signed [Q_W-1:0]  best_reg;
    logic [IDX_W-1:0]       best_a_reg;
    logic signed [Q_W-1:0]  old_reg;
    logic [G_W-1:0]         prod_g_reg;
    logic signed [T_W-1:0]  t_reg;
    logic signed [P_W-1:0]  p_reg;
    logic signed [Q_W-1:0]  new_reg;
    logic                   out_vld_reg;
    logic [IDX_W-1:0]       out_act_reg;
    logic signed [Q_W-1:0]  out_q_reg;

    logic signed [Q_W-1:0]  q_mem [TABLE_DEPTH];

    // Combinational terms
    logic [ADDR_W-1:0]      rd_addr;
    logic [ADDR_W-1:0]      wr_addr;
    logic [Q_W-1:0]         wr_data;
    logic                   wr_en;
    logic                   best_hit;
    logic                   out_free;
    logic [G_W-1:0]         prod_g_next;
    logic [G_W:0]           g_sum;
    logic [Q_W-1:0]         g_val;
    logic signed [T_W-1:0]  t_next;
    logic signed [P_W-1:0]  p_next;
    logic signed [P_W-1:0]  p_rnd;
    logic signed [T_W-1:0]  d_val;
    logic signed [Q_W+2:0]  sum_w;
    logic signed [Q_W-1:0]  new_next;

    assign out_free = !out_vld_reg || m_tready;

    assign status.clr_last  = &clr_cnt_reg;
    assign status.scan_last = (cnt_reg == LAST_ACT);
    assign status.out_free  = out_free;

    assign out_vld = out_vld_reg;
    assign out_act = out_act_reg;
    assign out_q   = out_q_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEARNING_RATE: alpha_reg <= cfg_data;
                CFG_DISCOUNT:      gamma_reg <= cfg_data;
                default:           alpha_reg <= alpha_reg;
            endcase
        end
    end

    // Latched request
    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= item;
    end

    // Table address select
    always_comb
    begin
        rd_addr = {item_reg.own_price_idx, item_reg.rival_price_idx, cnt_reg};
        unique case (cw.addr_sel)
            A_CUR_CNT: rd_addr = {item_reg.own_price_idx, item_reg.rival_price_idx, cnt_reg};
            A_NXT_CNT: rd_addr = {item_reg.next_own_idx, item_reg.next_rival_idx, cnt_reg};
            A_CUR_RND: rd_addr = {item_reg.own_price_idx, item_reg.rival_price_idx,
                                  item_reg.random_action};
            A_CUR_ACT: rd_addr = {item_reg.own_price_idx, item_reg.rival_price_idx,
                                  item_reg.action_idx};
            default:   rd_addr = {item_reg.own_price_idx, item_reg.rival_price_idx, cnt_reg};
        endcase
    end

    assign wr_en   = cw.clr_wr || cw.wr_upd;
    assign wr_addr = cw.clr_wr ? clr_cnt_reg
                               : {item_reg.own_price_idx, item_reg.rival_price_idx,
                                  item_reg.action_idx};
    assign wr_data = cw.clr_wr ? '0 : new_reg;

    // Q table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_addr] <= wr_data;
        rdata_reg <= q_mem[rd_addr];
    end

    // Clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cw.clr_wr)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Scan counter and compare pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cw.scan;
            if (in_accept)
                cnt_reg <= '0;
            else if (cw.scan)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw.scan)
            cmp_idx_reg <= cnt_reg;
    end

    // First strictly greater entry wins; greedy loads entry zero unconditionally
    assign best_hit = cw.cmp_en && cmp_vld_reg &&
                      ((cw.first_ld && cmp_idx_reg == '0) || (rdata_reg > best_reg));

    // Update arithmetic
    assign prod_g_next = gamma_reg * best_reg[Q_W-2:0];
    assign g_sum       = {1'b0, prod_g_reg} + (G_W+1)'(32768);
    assign g_val       = g_sum[G_W:FRAC_W];
    assign t_next      = T_W'(item_reg.reward) + T_W'(signed'({1'b0, g_val}))
                         - T_W'(old_reg);
    assign p_next      = t_reg * signed'({1'b0, alpha_reg});
    assign p_rnd       = p_reg + P_W'(32768);
    assign d_val       = p_rnd[P_W-1:FRAC_W];
    assign sum_w       = (Q_W+3)'(old_reg) + (Q_W+3)'(d_val);

    // Saturate to 32-bit signed
    always_comb
    begin
        priority if (sum_w > (Q_W+3)'(Q_MAX))
            new_next = Q_MAX;
        else if (sum_w < (Q_W+3)'(Q_MIN))
            new_next = Q_MIN;
        else
            new_next = sum_w[Q_W-1:0];
    end

    // Best value, best action and arithmetic stages
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            best_reg   <= '0;
            best_a_reg <= '0;
        end
        else if (cw.ld_exp)
        begin
            best_reg   <= rdata_reg;
            best_a_reg <= item_reg.random_action;
        end
        else if (cw.wr_upd)
        begin
            best_reg   <= new_reg;
            best_a_reg <= item_reg.action_idx;
        end
        else if (best_hit)
        begin
            best_reg   <= rdata_reg;
            best_a_reg <= cmp_idx_reg;
        end

        if (cw.ld_old)
        begin
            old_reg    <= rdata_reg;
            prod_g_reg <= prod_g_next;
        end
        if (cw.ld_t)
            t_reg <= t_next;
        if (cw.ld_p)
            p_reg <= p_next;
        if (cw.ld_new)
            new_reg <= new_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (cw.out_ld && out_free)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cw.out_ld && out_free)
        begin
            out_act_reg <= best_a_reg;
            out_q_reg   <= best_reg;
        end
    end

`include "tabular_q_learning_engine_unit_assert.svh"

    `TQLE_ASSERT_NXT(a_out_hold, out_vld_reg && !m_tready,
                     out_vld_reg && $stable(out_q_reg) && $stable(out_act_reg))
    `TQLE_ASSERT_IMP(a_max_nonneg, cw.ld_old, !best_reg[Q_W-1])
    `TQLE_ASSERT_IMP(a_cmp_range, cw.cmp_en && cmp_vld_reg, cmp_idx_reg <= LAST_ACT)

endmodule

/* rtl/tabular_q_learning_engine_unit.sv */
// Top level of the tabular Q-learning engine with epsilon-greedy choice.
//
//  channel | direction | fields (lowest bit first)
//  --------+-----------+---------------------------------------------------------
//  s_*     | in        | tuser: command; tdata: own, rival, action, reward,
//          |           |        next own, next rival, explore, random action
//  m_*     | out       | tdata: chosen_action, q_result
//  cfg_*   | in        | write enable, register index, 16-bit data
//
//  A greedy choice scans the 16 entries of the current state and an update those
//  of the next state, over the single table read port; an explore choice reads one entry.
//  After reset a clearing sweep writes zero to all 4096 entries, one a cycle;
//  s_tready stays low until the sweep ends.
//  A stalled result waits in the output register; the next request is accepted
//  meanwhile and its own result waits for the register to empty.
module tabular_q_learning_engine_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] own_price_idx, [7:4] rival_price_idx, [11:8] action_idx,
    // [43:12] reward, [47:44] next_own_idx, [51:48] next_rival_idx,
    // [52] explore, [56:53] random_action, [63:57] zero
    input  logic [tqle_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [3:0] chosen_action, [35:4] q_result, [39:36] zero
    output logic [tqle_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [tqle_pkg::FRAC_W-1:0]      cfg_data
);
    import tqle_pkg::*;

    step_t       upc;
    ucw_t        cw;
    in_item_t    item;
    dp_status_t  dp_status;
    seq_status_t seq_status;
    logic        in_accept;
    logic [IDX_W-1:0]      out_act;
    logic signed [Q_W-1:0] out_q;

    // Unpack the request
    assign item.command         = s_tuser;
    assign item.own_price_idx   = s_tdata[3:0];
    assign item.rival_price_idx = s_tdata[7:4];
    assign item.action_idx      = s_tdata[11:8];
    assign item.reward          = s_tdata[43:12];
    assign item.next_own_idx    = s_tdata[47:44];
    assign item.next_rival_idx  = s_tdata[51:48];
    assign item.explore         = s_tdata[52];
    assign item.random_action   = s_tdata[56:53];

    assign s_tready  = cw.in_rdy;
    assign in_accept = s_tvalid && cw.in_rdy;

    assign seq_status.in_valid   = s_tvalid;
    assign seq_status.in_cmd     = s_tuser;
    assign seq_status.in_explore = s_tdata[52];
    assign seq_status.dp         = dp_status;

    assign m_tdata = {4'b0000, out_q, out_act};

    tqle_ucode_rom u_rom (
        .upc (upc),
        .cw  (cw)
    );

    tqle_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cw    (cw),
        .st    (seq_status),
        .upc   (upc)
    );

    tqle_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .in_accept (in_accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .status    (dp_status),
        .out_vld   (m_tvalid),
        .out_act   (out_act),
        .out_q     (out_q)
    );

endmodule
